// ===== rtl/tprb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprb_pkg
// Shared types and constants of the timed packet ring buffer.
// ----------------------------------------------------------------------------
package tprb_pkg;

  localparam int BUF_BYTES = 65536;
  localparam int AW        = $clog2(BUF_BYTES);
  localparam int CW        = AW + 1;
  localparam int HDR_BYTES = 40;
  localparam int HDR_RD    = 33;
  localparam int EV_RD     = 12;
  localparam int LIMIT_W   = 36;
  localparam int DATA_W    = 192;
  localparam int WIN_W     = 12;
  localparam int LEN_W     = 17;
  localparam int CNT_W     = 6;
  localparam logic [23:0] TICKS = 24'd10000000;
  localparam logic [WIN_W-1:0] WIN_RESET = 12'd30;

  typedef enum logic [2:0] {
    OP_BEGIN  = 3'd0,
    OP_BYTE   = 3'd1,
    OP_REWIND = 3'd2,
    OP_NEXT   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_REJECT  = 3'd1,
    ST_IGNORED = 3'd2,
    ST_HEADER  = 3'd3,
    ST_BYTE    = 3'd4,
    ST_EMPTY   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    A_NONE, A_REJECT, A_LATCH, A_BYTE, A_REWIND, A_CLEAR, A_BYTE_RD, A_EV_RD,
    A_HDR_RD, A_DIFF, A_EVICT, A_HW_STEP, A_HW_DONE, A_HDR_OUT, A_BYTE_OUT
  } act_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EV_CHK, S_EV_RD, S_EV_DIFF, S_EV_DEC, S_HW, S_HW_DONE,
    S_HDR_RD, S_HDR_OUT, S_BYTE_RD
  } state_t;

  typedef struct packed {
    act_t             act;
    logic [CNT_W-1:0] cnt;
    logic             emit;
    status_t          status;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic too_big;
    logic open;
    logic used_nz;
    logic left_zero;
    logic pkt_zero;
    logic evict_now;
  } dp_stat_t;

endpackage

// ===== rtl/timed_packet_ring_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_packet_ring_buffer
// Packet ring buffer with size and age eviction and oldest-first readout.
// ----------------------------------------------------------------------------
// Channel  Direction  Carries
// s_*      in         item: tuser opcode, tdata request fields
// m_*      out        item: tuser status, tdata result fields, tlast last
// cfg_*    in         window length in seconds
//
// A payload byte, rewind, clear, rejected begin or empty next is handled in idle.
// A payload byte readout goes through the registered memory read.
// A header readout reads the header bytes, then emits; an accepted begin evicts
// oldest packets while the ring is over size or age, then writes the header.
// Reset is synchronous; the ring contents are not cleared, only the pointers.
// Input is held off while the result register is full and not being taken.
module timed_packet_ring_buffer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // stamp, span, key_frame, main_len, seq_len, pic_len, data_byte
  input  logic [tprb_pkg::DATA_W-1:0]       s_tdata,
  // opcode
  input  logic [2:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_stamp, out_span, out_key_frame, out_main_len, out_seq_len,
  // out_pic_len, out_byte
  output logic [tprb_pkg::DATA_W-1:0]       m_tdata,
  // status
  output logic [2:0]                        m_tuser,
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tprb_pkg::WIN_W-1:0]        cfg_data
);
  import tprb_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  tprb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_op    (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tprb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_data    (s_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_status (m_tuser),
    .out_last   (m_tlast)
  );

endmodule

// ===== rtl/tprb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprb_ctrl
// Sequencer that walks eviction, header writes and header reads.
// ----------------------------------------------------------------------------
module tprb_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [2:0]               in_op,
  output logic                     in_ready,
  input  tprb_pkg::dp_stat_t       stat,
  output tprb_pkg::cmd_t           cmd
);
  import tprb_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd.act    = A_NONE;
    cmd.cnt    = cnt;
    cmd.emit   = 1'b0;
    cmd.status = ST_DONE;
    case (state)
      S_IDLE: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          case (op_t'(in_op))
            OP_BEGIN: begin
              if (stat.too_big) begin
                cmd.act    = A_REJECT;
                cmd.emit   = 1'b1;
                cmd.status = ST_REJECT;
              end else begin
                cmd.act    = A_LATCH;
                state_next = S_EV_CHK;
              end
            end
            OP_BYTE: begin
              cmd.emit = 1'b1;
              if (stat.open) begin
                cmd.act = A_BYTE;
              end else begin
                cmd.status = ST_IGNORED;
              end
            end
            OP_REWIND: begin
              cmd.act  = A_REWIND;
              cmd.emit = 1'b1;
            end
            OP_CLEAR: begin
              cmd.act  = A_CLEAR;
              cmd.emit = 1'b1;
            end
            OP_NEXT: begin
              if (stat.left_zero) begin
                cmd.emit   = 1'b1;
                cmd.status = ST_EMPTY;
              end else if (stat.pkt_zero) begin
                cnt_next   = '0;
                state_next = S_HDR_RD;
              end else begin
                cmd.act    = A_BYTE_RD;
                state_next = S_BYTE_RD;
              end
            end
            default: begin
              cmd.emit   = 1'b1;
              cmd.status = ST_IGNORED;
            end
          endcase
        end
      end
      S_EV_CHK: begin
        cnt_next   = '0;
        state_next = stat.used_nz ? S_EV_RD : S_HW;
      end
      S_EV_RD: begin
        cmd.act  = A_EV_RD;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(EV_RD)) begin
          state_next = S_EV_DIFF;
        end
      end
      S_EV_DIFF: begin
        cmd.act    = A_DIFF;
        state_next = S_EV_DEC;
      end
      S_EV_DEC: begin
        cnt_next = '0;
        if (stat.evict_now) begin
          cmd.act    = A_EVICT;
          state_next = S_EV_CHK;
        end else begin
          state_next = S_HW;
        end
      end
      S_HW: begin
        cmd.act  = A_HW_STEP;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(HDR_BYTES - 1)) begin
          state_next = S_HW_DONE;
        end
      end
      S_HW_DONE: begin
        if (stat.out_free) begin
          cmd.act    = A_HW_DONE;
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_HDR_RD: begin
        cmd.act  = A_HDR_RD;
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(HDR_RD)) begin
          state_next = S_HDR_OUT;
        end
      end
      S_HDR_OUT: begin
        if (stat.out_free) begin
          cmd.act    = A_HDR_OUT;
          cmd.emit   = 1'b1;
          cmd.status = ST_HEADER;
          state_next = S_IDLE;
        end
      end
      S_BYTE_RD: begin
        if (stat.out_free) begin
          cmd.act    = A_BYTE_OUT;
          cmd.emit   = 1'b1;
          cmd.status = ST_BYTE;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/tprb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tprb_dp
// Byte ring memory, ring pointers, header buffer and the result register.
// ----------------------------------------------------------------------------
module tprb_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tprb_pkg::DATA_W-1:0]   in_data,
  input  logic                          cfg_valid,
  input  logic [tprb_pkg::WIN_W-1:0]    cfg_data,
  input  tprb_pkg::cmd_t                cmd,
  output tprb_pkg::dp_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tprb_pkg::DATA_W-1:0]   out_data,
  output logic [2:0]                    out_status,
  output logic                          out_last
);
  import tprb_pkg::*;

  logic [7:0] mem [BUF_BYTES];
  logic [7:0] rdata;
  logic       rd_en;
  logic [AW-1:0] rd_addr;
  logic       wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0] wr_byte;

  logic [LIMIT_W-1:0] limit;
  logic [AW-1:0] oldest_pos, commit_pos, fill_pos, readout_pos;
  logic [CW-1:0] used_bytes, bytes_pending, readout_left, pkt_left, open_total;
  logic          packet_open;

  logic [63:0] stamp_r, span_r;
  logic        key_r;
  logic [LEN_W-1:0] ml_r, sl_r, pl_r;
  logic [CW-1:0] tot_r, pay_r;
  logic [63:0] diff;
  logic [7:0]  hdr [HDR_RD];

  logic [LEN_W+1:0] in_pay, in_tot;
  logic [8*HDR_BYTES-1:0] hw_vec;
  logic [31:0] hdr_total;
  logic [CW:0] fit_sum;
  logic [CNT_W-1:0] cap_idx;

  logic [31:0] t_sel;
  logic [CW-1:0] left_n, pkt_n;

  logic [DATA_W-1:0] out_data_next;
  logic              out_last_next;

  assign in_pay = {2'b0, in_data[145:129]} + {2'b0, in_data[162:146]}
                + {2'b0, in_data[179:163]};
  assign in_tot = in_pay + (LEN_W+2)'(HDR_BYTES);

  assign hw_vec = {56'b0, {15'b0, pl_r}, {15'b0, sl_r}, {15'b0, ml_r}, {7'b0, key_r},
                   span_r, stamp_r, {{(32-CW){1'b0}}, tot_r}};
  assign hdr_total = {hdr[3], hdr[2], hdr[1], hdr[0]};
  assign fit_sum = {1'b0, used_bytes} + {1'b0, tot_r};
  assign cap_idx = cmd.cnt - CNT_W'(1);

  always_comb begin
    if (hdr_total < 32'(HDR_BYTES) || hdr_total > 32'(readout_left)) begin
      t_sel = (readout_left < CW'(HDR_BYTES)) ? 32'(HDR_BYTES) : 32'(readout_left);
    end else begin
      t_sel = hdr_total;
    end
    left_n = (readout_left > CW'(HDR_BYTES)) ? readout_left - CW'(HDR_BYTES) : '0;
    pkt_n  = CW'(t_sel - 32'(HDR_BYTES));
    if (pkt_n > left_n) begin
      pkt_n = left_n;
    end
  end

  always_comb begin
    stat.out_free  = !out_valid || out_ready;
    stat.too_big   = in_tot > (LEN_W+2)'(BUF_BYTES);
    stat.open      = packet_open;
    stat.used_nz   = used_bytes != '0;
    stat.left_zero = readout_left == '0;
    stat.pkt_zero  = pkt_left == '0;
    stat.evict_now = (fit_sum > (CW+1)'(BUF_BYTES))
                   || (!diff[63] && diff > {{(64-LIMIT_W){1'b0}}, limit});
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = readout_pos;
    wr_en   = 1'b0;
    wr_addr = fill_pos;
    wr_byte = in_data[187:180];
    case (cmd.act)
      A_BYTE_RD: begin
        rd_en = 1'b1;
      end
      A_EV_RD: begin
        rd_en   = cmd.cnt < CNT_W'(EV_RD);
        rd_addr = oldest_pos + AW'(cmd.cnt);
      end
      A_HDR_RD: begin
        rd_en   = cmd.cnt < CNT_W'(HDR_RD);
        rd_addr = readout_pos + AW'(cmd.cnt);
      end
      A_BYTE: begin
        wr_en = 1'b1;
      end
      A_HW_STEP: begin
        wr_en   = 1'b1;
        wr_addr = commit_pos + AW'(cmd.cnt);
        wr_byte = hw_vec[8*cmd.cnt +: 8];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_byte;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if ((cmd.act == A_EV_RD || cmd.act == A_HDR_RD) && cmd.cnt != '0) begin
      hdr[cap_idx] <= rdata;
    end
    if (cmd.act == A_LATCH) begin
      stamp_r <= in_data[63:0];
      span_r  <= in_data[127:64];
      key_r   <= in_data[128];
      ml_r    <= in_data[145:129];
      sl_r    <= in_data[162:146];
      pl_r    <= in_data[179:163];
      tot_r   <= CW'(in_tot);
      pay_r   <= CW'(in_pay);
    end
    if (cmd.act == A_DIFF) begin
      diff <= stamp_r - {hdr[11], hdr[10], hdr[9], hdr[8], hdr[7], hdr[6], hdr[5], hdr[4]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_W'(WIN_RESET) * LIMIT_W'(TICKS);
    end else if (cfg_valid) begin
      limit <= LIMIT_W'(cfg_data) * LIMIT_W'(TICKS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_pos    <= '0;
      commit_pos    <= '0;
      fill_pos      <= '0;
      readout_pos   <= '0;
      used_bytes    <= '0;
      bytes_pending <= '0;
      readout_left  <= '0;
      pkt_left      <= '0;
      open_total    <= '0;
      packet_open   <= 1'b0;
    end else begin
      case (cmd.act)
        A_REJECT, A_LATCH: begin
          packet_open   <= 1'b0;
          bytes_pending <= '0;
        end
        A_BYTE: begin
          fill_pos      <= fill_pos + AW'(1);
          bytes_pending <= bytes_pending - CW'(1);
          if (bytes_pending == CW'(1)) begin
            commit_pos  <= commit_pos + AW'(open_total);
            used_bytes  <= used_bytes + open_total;
            packet_open <= 1'b0;
          end
        end
        A_REWIND: begin
          readout_pos  <= oldest_pos;
          readout_left <= used_bytes;
          pkt_left     <= '0;
        end
        A_CLEAR: begin
          oldest_pos    <= '0;
          commit_pos    <= '0;
          fill_pos      <= '0;
          readout_pos   <= '0;
          used_bytes    <= '0;
          bytes_pending <= '0;
          readout_left  <= '0;
          pkt_left      <= '0;
          packet_open   <= 1'b0;
        end
        A_EVICT: begin
          if (hdr_total > 32'(used_bytes) || hdr_total == '0) begin
            oldest_pos <= oldest_pos + AW'(used_bytes);
            used_bytes <= '0;
          end else begin
            oldest_pos <= oldest_pos + AW'(hdr_total);
            used_bytes <= used_bytes - CW'(hdr_total);
          end
          readout_left <= '0;
          pkt_left     <= '0;
        end
        A_HW_DONE: begin
          fill_pos      <= commit_pos + AW'(HDR_BYTES);
          bytes_pending <= pay_r;
          open_total    <= tot_r;
          if (pay_r == '0) begin
            commit_pos <= commit_pos + AW'(tot_r);
            used_bytes <= used_bytes + tot_r;
          end else begin
            packet_open <= 1'b1;
          end
        end
        A_HDR_OUT: begin
          readout_pos  <= readout_pos + AW'(HDR_BYTES);
          readout_left <= left_n;
          pkt_left     <= pkt_n;
        end
        A_BYTE_OUT: begin
          readout_pos  <= readout_pos + AW'(1);
          readout_left <= readout_left - CW'(1);
          pkt_left     <= pkt_left - CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    out_data_next = '0;
    out_last_next = 1'b0;
    if (cmd.act == A_HDR_OUT) begin
      out_data_next[63:0]    = {hdr[11], hdr[10], hdr[9], hdr[8],
                                hdr[7], hdr[6], hdr[5], hdr[4]};
      out_data_next[127:64]  = {hdr[19], hdr[18], hdr[17], hdr[16],
                                hdr[15], hdr[14], hdr[13], hdr[12]};
      out_data_next[128]     = hdr[20][0];
      out_data_next[145:129] = {hdr[23][0], hdr[22], hdr[21]};
      out_data_next[162:146] = {hdr[27][0], hdr[26], hdr[25]};
      out_data_next[179:163] = {hdr[31][0], hdr[30], hdr[29]};
      out_last_next          = left_n == '0;
    end else if (cmd.act == A_BYTE_OUT) begin
      out_data_next[187:180] = rdata;
      out_last_next          = readout_left == CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.status;
      out_data   <= out_data_next;
      out_last   <= out_last_next;
    end
  end

endmodule
